>>> sv/dsfp_pkg.sv
package dsfp_pkg;

   // Frame geometry and batch length.
   localparam int FRAME_BYTES = 11;
   localparam int BATCH_BYTES = 128;
   localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
   localparam int COUNT_W     = $clog2(BATCH_BYTES + 1);

   localparam logic [FILL_W-1:0]  FILL_FULL   = FILL_W'(FRAME_BYTES);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(BATCH_BYTES);

   // Frame header and bypass type bytes.
   localparam logic [7:0] HDR0_BYTE  = 8'hFE;
   localparam logic [7:0] HDR1_BYTE  = 8'hA5;
   localparam logic [7:0] TYPE0_BYTE = 8'h02;
   localparam logic [7:0] TYPE1_BYTE = 8'h00;

   // Register reset values.
   localparam logic [15:0] LIMIT_RESET  = 16'd2500;
   localparam logic [7:0]  OFFSET_RESET = 8'd2;

   // Register map, byte address 4 * index.
   localparam int          CSR_ADDR_W = 4;
   localparam logic [1:0]  REG_LIMIT       = 2'd0;
   localparam logic [1:0]  REG_OFFSET      = 2'd1;
   localparam logic [1:0]  REG_OFFSET_EN   = 2'd2;
   localparam logic [1:0]  REG_BYPASS_EN   = 2'd3;

   // Result status codes.
   localparam logic STATUS_READING  = 1'b0;
   localparam logic STATUS_CSUM_ERR = 1'b1;

   typedef logic [7:0] byte_type;

endpackage

>>> sv/dust_sensor_frame_parser_core.sv
// Channel   | Direction | Handshake              | Beat payload
// ----------+-----------+------------------------+--------------------------------------------
// req       | in        | req_valid / req_stall  | req_rx_byte, req_batch_start
// rsp       | out       | rsp_valid / rsp_stall  | rsp_status, rsp_pm*_value, checksums, total
// csr       | in/out    | psel/penable/pready    | paddr, pwrite, pwdata, prdata
//
// The block accepts a byte in every cycle in which the result register is not holding a
// stalled beat. A byte enters the window register when it is accepted, the check logic
// works on that window, and the result register loads the check result when both stages
// advance, so a result beat is presented from the result register after its byte has
// passed the window register.
// The synchronous reset clears the control state, the reading counter and restores the
// register defaults. A stall on rsp freezes both stages and raises req_stall in the same cycle.
module dust_sensor_frame_parser_core
   import dsfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   input  logic                  req_batch_start,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output logic [15:0]           rsp_pm1_value,
   output logic [15:0]           rsp_pm25_value,
   output logic [15:0]           rsp_pm10_value,
   output logic [7:0]            rsp_received_checksum,
   output logic [7:0]            rsp_computed_checksum,
   output logic [31:0]           rsp_reading_total,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [15:0] limit_ff;
   logic [7:0]  offset_ff;
   logic        offset_en_ff;
   logic        bypass_en_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         offset_ff    <= OFFSET_RESET;
         offset_en_ff <= 1'b1;
         bypass_en_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            REG_LIMIT:     limit_ff     <= pwdata[15:0];
            REG_OFFSET:    offset_ff    <= pwdata[7:0];
            REG_OFFSET_EN: offset_en_ff <= pwdata[0];
            REG_BYPASS_EN: bypass_en_ff <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LIMIT:     prdata = {16'd0, limit_ff};
         REG_OFFSET:    prdata = {24'd0, offset_ff};
         REG_OFFSET_EN: prdata = {31'd0, offset_en_ff};
         REG_BYPASS_EN: prdata = {31'd0, bypass_en_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline control. Both stages move together whenever the result
   // register is free or being drained this cycle.
   // ------------------------------------------------------------------
   logic rsp_valid_ff;
   logic advance;
   logic req_accept;

   assign advance    = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !advance;
   assign req_accept = req_valid && advance;

   // ------------------------------------------------------------------
   // Stage A: the byte window. A batch start discards the old window and
   // byte count; once the batch has its full length, further bytes are dropped.
   // ------------------------------------------------------------------
   byte_type           win_ff [FRAME_BYTES];
   byte_type           win_in [FRAME_BYTES];
   logic [FILL_W-1:0]  fill_ff,  fill_in,  base_fill;
   logic [COUNT_W-1:0] count_ff, count_in, base_count;
   logic               a_valid_ff, a_eval_ff, a_clear_ff;
   logic               a_eval_in;
   logic               dropped;

   always_comb begin
      base_fill  = req_batch_start ? '0 : fill_ff;
      base_count = req_batch_start ? '0 : count_ff;
      dropped    = (base_count >= COUNT_LIMIT);

      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[FRAME_BYTES - 1] = req_rx_byte;

      if (dropped) begin
         fill_in  = fill_ff;
         count_in = count_ff;
      end else begin
         count_in = base_count + COUNT_W'(1);
         fill_in  = (base_fill < FILL_FULL) ? base_fill + FILL_W'(1) : base_fill;
      end
      a_eval_in = !dropped && (fill_in == FILL_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
         a_eval_ff  <= 1'b0;
         a_clear_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_accept;
         a_eval_ff  <= req_accept && a_eval_in;
         a_clear_ff <= req_accept && req_batch_start;
         if (req_accept) begin
            fill_ff  <= fill_in;
            count_ff <= count_in;
         end
      end
   end

   // The window contents are only looked at once the fill count says they
   // are all from the current batch, so they carry no reset.
   always_ff @(posedge clock) begin
      if (advance && req_accept && !dropped) begin
         win_ff <= win_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: frame check on the window left by the previous byte.
   // ------------------------------------------------------------------
   logic        found_ff, found_in, found_now;
   logic [31:0] counter_ff, counter_in;
   logic        header_hit;
   logic [7:0]  calc_sum;
   logic [7:0]  rcv_sum;
   logic        csum_ok;
   logic [15:0] pm1, pm25, pm10;
   logic        in_limit;
   logic        fire;
   logic        reading;

   assign header_hit = (win_ff[0] == HDR0_BYTE) && (win_ff[1] == HDR1_BYTE);
   assign calc_sum   = ((win_ff[0] + win_ff[1]) + (win_ff[2] + win_ff[3]))
                     + ((win_ff[4] + win_ff[5]) + (win_ff[6] + win_ff[7]))
                     + (win_ff[8] + win_ff[9]);
   assign rcv_sum    = win_ff[10];

   // Accept the checksum as sent, with the extra offset when enabled, or on the bypass type when enabled.
   assign csum_ok = (rcv_sum == calc_sum)
                 || (offset_en_ff && (rcv_sum == 8'(calc_sum + offset_ff)))
                 || (bypass_en_ff && (win_ff[2] == TYPE0_BYTE) && (win_ff[3] == TYPE1_BYTE));

   assign pm1      = {win_ff[4], win_ff[5]};
   assign pm25     = {win_ff[6], win_ff[7]};
   assign pm10     = {win_ff[8], win_ff[9]};
   assign in_limit = (pm1 <= limit_ff) && (pm25 <= limit_ff) && (pm10 <= limit_ff);

   // A batch start clears the found flag before its own byte is judged.
   assign found_now = found_ff && !a_clear_ff;
   assign reading   = a_eval_ff && !found_now && header_hit && csum_ok && in_limit;
   assign fire      = a_eval_ff && !found_now && header_hit && (!csum_ok || in_limit);
   assign found_in  = found_now || reading;
   assign counter_in = reading ? counter_ff + 32'd1 : counter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fire;
         if (a_valid_ff) begin
            found_ff   <= found_in;
            counter_ff <= counter_in;
         end
      end
   end

   logic        status_ff;
   logic [15:0] pm1_ff, pm25_ff, pm10_ff;
   logic [7:0]  rcv_ff, calc_ff;
   logic [31:0] total_ff;

   always_ff @(posedge clock) begin
      if (advance && fire) begin
         status_ff <= csum_ok ? STATUS_READING : STATUS_CSUM_ERR;
         pm1_ff    <= csum_ok ? pm1  : 16'd0;
         pm25_ff   <= csum_ok ? pm25 : 16'd0;
         pm10_ff   <= csum_ok ? pm10 : 16'd0;
         rcv_ff    <= rcv_sum;
         calc_ff   <= calc_sum;
         total_ff  <= counter_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_pm1_value         = pm1_ff;
   assign rsp_pm25_value        = pm25_ff;
   assign rsp_pm10_value        = pm10_ff;
   assign rsp_received_checksum = rcv_ff;
   assign rsp_computed_checksum = calc_ff;
   assign rsp_reading_total     = total_ff;

endmodule

>>> sv/dsfp_checker.sv
module dsfp_checker
   import dsfp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic [15:0] rsp_pm1_value,
   input logic [15:0] rsp_pm25_value,
   input logic [15:0] rsp_pm10_value,
   input logic [31:0] rsp_reading_total,
   input logic        pready
);

   // A stalled result beat stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reading_total)
         && $stable(rsp_status) && $stable(rsp_pm1_value))
      else $error("stalled result beat changed");

   // The input side is only held back by a stalled result.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // A checksum error carries no concentrations.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_CSUM_ERR) |->
         (rsp_pm1_value == 16'd0) && (rsp_pm25_value == 16'd0) && (rsp_pm10_value == 16'd0))
      else $error("checksum error beat with nonzero concentration");

   // Two readings taken back to back are numbered one apart.
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_status == STATUS_READING)
         ##1 rsp_valid && (rsp_status == STATUS_READING) && !$past(reset) |->
         rsp_reading_total == $past(rsp_reading_total) + 32'd1)
      else $error("reading total did not advance by one");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready && (req_valid || !req_valid))
      else $error("pready dropped");

endmodule

bind dust_sensor_frame_parser_core dsfp_checker u_dsfp_checker (.*);
